FILE: rtl/word_frequency_table_defines.svh
// Assertion macros used by the word frequency table module.
`ifndef WORD_FREQUENCY_TABLE_DEFINES_SVH
`define WORD_FREQUENCY_TABLE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define WFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check a condition in the cycle after its trigger.
`define WFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/wft_pkg.sv
`timescale 1ns / 1ps

package wft_pkg;

	localparam int MAX_ENTRIES_DEF  = 128;
	localparam int MAX_WORD_LEN_DEF = 80;
	localparam int COUNT_WIDTH_DEF  = 16;

	// Result status codes
	localparam logic [1:0] ST_EXISTING = 2'd0;
	localparam logic [1:0] ST_NEW      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	// Delimiter byte codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_PERIOD  = 8'h2E;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} char_t;

	typedef struct packed {
		logic [6:0]  entry_index;
		logic [15:0] occurrence_count;
		logic [6:0]  word_length;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [1:0] {
		FSM_COLLECT,
		FSM_SEARCH,
		FSM_EMIT
	} fsm_t;

	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_NEWLINE) || (c == CH_COMMA) || (c == CH_PERIOD);
	endfunction

endpackage

FILE: rtl/word_frequency_table.sv
// Word frequency table.
// Input channel char_valid / char_stall / char_data carries one text byte per
// beat with an end_of_text mark. Space, newline, comma, period and the end mark end a word.
// Output channel result_valid / result_stall / result_data carries one beat
// per completed word: entry index, count, length and status.
// While collecting, a byte that does not end a word is taken without a stall. A word end
// scans the entries in use, one row per cycle from the table memory, and
// holds char_stall high through the scan and the result hand-off; a match
// ends the scan early. An overlong word skips the scan. The result is
// registered in res_q and then in the output register out_q, which waits
// while the receiver stalls.
// Reset clears the word buffer length, the entry count and the handshakes;
// table rows are written before they are read and need no clearing.
// While the receiver stalls, the result register holds its beat; the block
// keeps taking bytes until the next word end, then waits to hand off.
`timescale 1ns / 1ps
`include "word_frequency_table_defines.svh"

module word_frequency_table #(
	parameter int MAX_ENTRIES  = wft_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_WORD_LEN = wft_pkg::MAX_WORD_LEN_DEF,
	parameter int COUNT_WIDTH  = wft_pkg::COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  wft_pkg::char_t   char_data,
	output logic             result_valid,
	input  logic             result_stall,
	output wft_pkg::result_t result_data
);

	localparam int IDX_W   = $clog2(MAX_ENTRIES);
	localparam int USED_W  = $clog2(MAX_ENTRIES + 1);
	localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
	localparam int POS_W   = $clog2(MAX_WORD_LEN);
	localparam int CHARS_W = MAX_WORD_LEN * 8;
	localparam int ROW_W   = CHARS_W + LEN_W + COUNT_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	wft_pkg::fsm_t    state_q, state_d;
	logic [7:0]       word_q [MAX_WORD_LEN];
	logic [LEN_W-1:0] len_q;
	logic             ovl_q;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] rd_q;
	logic             rvalid_s1;
	logic [IDX_W-1:0] ridx_s1;
	wft_pkg::result_t res_q, res_d;
	wft_pkg::result_t out_q;
	logic             out_valid_q;

	logic             accept, is_d, append, ovl_n, finish;
	logic [LEN_W-1:0] len_n;
	logic             rd_en, wr_en, new_entry, load_res, load_out, leave_search;
	logic [IDX_W-1:0] wr_addr;
	logic [ROW_W-1:0] wr_data, rd_data;
	logic [CHARS_W-1:0] word_flat, row_chars;
	logic [LEN_W-1:0] row_len;
	logic [COUNT_WIDTH-1:0] row_cnt, cnt_new;
	logic             diff, match;

	wft_table #(.ROWS(MAX_ENTRIES), .ROW_W(ROW_W)) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_q[IDX_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Decode the incoming byte
	assign accept = char_valid && !char_stall;
	assign is_d   = wft_pkg::is_delim(char_data.char_code);
	assign append = accept && !is_d && (len_q < LEN_W'(MAX_WORD_LEN));
	assign len_n  = append ? len_q + LEN_W'(1) : len_q;
	assign ovl_n  = ovl_q || (accept && !is_d && !(len_q < LEN_W'(MAX_WORD_LEN)));
	assign finish = accept && (is_d || char_data.end_of_text);

	// Split the row read back and compare it with the word buffer
	assign row_chars = rd_data[ROW_W-1 -: CHARS_W];
	assign row_len   = rd_data[COUNT_WIDTH +: LEN_W];
	assign row_cnt   = rd_data[COUNT_WIDTH-1:0];
	assign cnt_new   = (row_cnt == CNT_MAX) ? row_cnt : row_cnt + COUNT_WIDTH'(1);

	always_comb begin
		diff = 1'b0;
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			word_flat[i*8 +: 8] = word_q[i];
			if ((LEN_W'(i) < len_q) && (row_chars[i*8 +: 8] != word_q[i])) begin
				diff = 1'b1;
			end
		end
	end

	assign match = rvalid_s1 && (row_len == len_q) && !diff;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wft_pkg::FSM_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, table access and result selection
	always_comb begin
		state_d      = state_q;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = ridx_s1;
		wr_data      = {row_chars, row_len, cnt_new};
		new_entry    = 1'b0;
		load_res     = 1'b0;
		load_out     = 1'b0;
		leave_search = 1'b0;
		res_d        = '0;
		char_stall   = (state_q != wft_pkg::FSM_COLLECT);
		case (state_q)
			wft_pkg::FSM_COLLECT: begin
				if (finish && ovl_n) begin
					res_d.word_length = 7'(MAX_WORD_LEN);
					res_d.status      = wft_pkg::ST_TOO_LONG;
					load_res          = 1'b1;
					state_d           = wft_pkg::FSM_EMIT;
				end else if (finish && (len_n != '0)) begin
					state_d = wft_pkg::FSM_SEARCH;
				end
			end
			wft_pkg::FSM_SEARCH: begin
				rd_en = (rd_q != used_q);
				if (match) begin
					wr_en                  = 1'b1;
					res_d.entry_index      = 7'(ridx_s1);
					res_d.occurrence_count = 16'(cnt_new);
					res_d.word_length      = 7'(len_q);
					res_d.status           = wft_pkg::ST_EXISTING;
					load_res               = 1'b1;
					leave_search           = 1'b1;
					state_d                = wft_pkg::FSM_EMIT;
				end else if (rd_q == used_q) begin
					res_d.word_length = 7'(len_q);
					if (used_q < USED_W'(MAX_ENTRIES)) begin
						wr_en                  = 1'b1;
						new_entry              = 1'b1;
						wr_addr                = used_q[IDX_W-1:0];
						wr_data                = {word_flat, len_q, COUNT_WIDTH'(1)};
						res_d.entry_index      = 7'(used_q);
						res_d.occurrence_count = 16'd1;
						res_d.status           = wft_pkg::ST_NEW;
					end else begin
						res_d.status = wft_pkg::ST_FULL;
					end
					load_res     = 1'b1;
					leave_search = 1'b1;
					state_d      = wft_pkg::FSM_EMIT;
				end
			end
			wft_pkg::FSM_EMIT: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = wft_pkg::FSM_COLLECT;
				end
			end
			default: begin
				state_d = wft_pkg::FSM_COLLECT;
			end
		endcase
	end

	// Append the byte to the word buffer
	always_ff @(posedge clk) begin
		if (append) begin
			word_q[len_q[POS_W-1:0]] <= char_data.char_code;
		end
	end

	// Track word length, overflow and entries in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovl_q  <= 1'b0;
			used_q <= '0;
		end else begin
			if (finish && ovl_n) begin
				len_q <= '0;
				ovl_q <= 1'b0;
			end else if (accept) begin
				len_q <= len_n;
				ovl_q <= ovl_n;
			end else if (leave_search) begin
				len_q <= '0;
			end
			if (new_entry) begin
				used_q <= used_q + USED_W'(1);
			end
		end
	end

	// Advance the scan address and the read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q      <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			if (state_q != wft_pkg::FSM_SEARCH) begin
				rd_q <= '0;
			end else if (rd_en) begin
				rd_q <= rd_q + USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ridx_s1 <= rd_q[IDX_W-1:0];
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	`WFT_ASSERT_NOW(a_used_bound, clk, arst_n, 1'b1, used_q <= USED_W'(MAX_ENTRIES))
	`WFT_ASSERT_NEXT(a_new_grows, clk, arst_n, new_entry, used_q == $past(used_q) + USED_W'(1))
	`WFT_ASSERT_NOW(a_check_in_use, clk, arst_n, rvalid_s1, USED_W'(ridx_s1) < used_q)
	`WFT_ASSERT_NOW(a_no_read_collect, clk, arst_n, accept, !rd_en && !wr_en)

endmodule

FILE: rtl/wft_table.sv
`timescale 1ns / 1ps

module wft_table #(
	parameter int ROWS  = wft_pkg::MAX_ENTRIES_DEF,
	parameter int ROW_W = 8
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [$clog2(ROWS)-1:0] rd_addr,
	output logic [ROW_W-1:0]        rd_data,
	input  logic                    wr_en,
	input  logic [$clog2(ROWS)-1:0] wr_addr,
	input  logic [ROW_W-1:0]        wr_data
);

	logic [ROW_W-1:0] mem [ROWS];

	// Write one row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one row, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: tb/sv/word_frequency_table_tb.sv
`timescale 1ns / 1ps

module word_frequency_table_tb;

	localparam int TABLE_SIZE = 128;
	localparam int WORD_MAX   = 80;
	localparam int COUNT_TOP  = 65535;
	localparam int VOCAB_SIZE = 160;

	typedef logic [7:0] byte_q_t[$];

	// Word table tracker: mirrors the stored words and holds expected beats
	class word_tally_board;
		logic [7:0]       stored_chars[TABLE_SIZE][WORD_MAX];
		int               stored_len[TABLE_SIZE];
		int               stored_count[TABLE_SIZE];
		int               used;
		logic [7:0]       word_buf[WORD_MAX];
		int               word_len;
		bit               too_long;
		wft_pkg::result_t awaited[$];
		int               errors;

		function new();
			used = 0;
			word_len = 0;
			too_long = 0;
			errors = 0;
		endfunction

		function bit is_sep(logic [7:0] c);
			return c == wft_pkg::CH_SPACE || c == wft_pkg::CH_NEWLINE ||
				c == wft_pkg::CH_COMMA || c == wft_pkg::CH_PERIOD;
		endfunction

		// Close the pending word and queue its expected beat, if any
		function void close_word();
			wft_pkg::result_t r;
			int e;
			bit same;
			r = '0;
			if (too_long) begin
				word_len = 0;
				too_long = 0;
				r.word_length = 7'(WORD_MAX);
				r.status = wft_pkg::ST_TOO_LONG;
				awaited.push_back(r);
				return;
			end
			if (word_len == 0)
				return;
			r.word_length = 7'(word_len);
			for (e = 0; e < used; e++) begin
				same = (stored_len[e] == word_len);
				for (int i = 0; same && i < word_len; i++)
					if (stored_chars[e][i] != word_buf[i])
						same = 0;
				if (same) begin
					if (stored_count[e] < COUNT_TOP)
						stored_count[e]++;
					r.entry_index = 7'(e);
					r.occurrence_count = 16'(stored_count[e]);
					r.status = wft_pkg::ST_EXISTING;
					awaited.push_back(r);
					word_len = 0;
					return;
				end
			end
			if (used >= TABLE_SIZE) begin
				r.status = wft_pkg::ST_FULL;
			end else begin
				for (int i = 0; i < word_len; i++)
					stored_chars[used][i] = word_buf[i];
				stored_len[used] = word_len;
				stored_count[used] = 1;
				r.entry_index = 7'(used);
				r.occurrence_count = 16'd1;
				r.status = wft_pkg::ST_NEW;
				used++;
			end
			word_len = 0;
			awaited.push_back(r);
		endfunction

		// Note an accepted input beat
		function void note_char(wft_pkg::char_t c);
			if (is_sep(c.char_code)) begin
				close_word();
				return;
			end
			if (word_len < WORD_MAX) begin
				word_buf[word_len] = c.char_code;
				word_len++;
			end else begin
				too_long = 1;
			end
			if (c.end_of_text)
				close_word();
		endfunction

		// Compare an accepted result beat against the oldest expectation
		function void check_result(wft_pkg::result_t got);
			wft_pkg::result_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result beat %h", got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.entry_index !== want.entry_index) begin
				$error("entry_index expected %0d actual %0d",
					want.entry_index, got.entry_index);
				errors++;
			end
			if (got.occurrence_count !== want.occurrence_count) begin
				$error("occurrence_count expected %0d actual %0d",
					want.occurrence_count, got.occurrence_count);
				errors++;
			end
			if (got.word_length !== want.word_length) begin
				$error("word_length expected %0d actual %0d",
					want.word_length, got.word_length);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 0;
	logic             arst_n = 0;
	logic             char_valid = 0;
	logic             char_stall;
	wft_pkg::char_t   char_data = '0;
	logic             result_valid;
	logic             result_stall = 0;
	wft_pkg::result_t result_data;

	word_tally_board tally = new();
	bit      calm = 0;
	bit      hold_request = 0;
	int      hold_left = 0;
	byte_q_t vocab[VOCAB_SIZE];

	word_frequency_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data(char_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	always #4 clk = ~clk;

	initial begin
		#(40_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	// Take result beats; stall at random or during a long hold-off
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			tally.check_result(result_data);
		if (hold_request) begin
			hold_request = 0;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
		end
	end

	// Offer one input beat, idling at random first, and hold it until taken
	task automatic send_char(logic [7:0] code, logic eot);
		wft_pkg::char_t c;
		c.char_code = code;
		c.end_of_text = eot;
		while (!calm && $urandom_range(99) < 34) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data <= c;
		do @(posedge clk); while (char_stall);
		tally.note_char(c);
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (tally.is_sep(b));
		return b;
	endfunction

	function automatic logic [7:0] sep_byte();
		case ($urandom_range(3))
			0: return wft_pkg::CH_SPACE;
			1: return wft_pkg::CH_NEWLINE;
			2: return wft_pkg::CH_COMMA;
			default: return wft_pkg::CH_PERIOD;
		endcase
	endfunction

	// Send a word, ending it with a run of delimiters or with the end mark
	task automatic send_word(byte_q_t w, output int sent);
		bit eot_end;
		int n;
		eot_end = ($urandom_range(9) == 0);
		sent = 0;
		foreach (w[i]) begin
			send_char(w[i], eot_end && i == w.size() - 1);
			sent++;
		end
		if (!eot_end) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				send_char(sep_byte(), $urandom_range(7) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		byte_q_t w;
		int sent;
		int total;
		int len;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, every delimiter, delimiter runs, end marks
		send_char(8'h00, 0);
		send_char(wft_pkg::CH_SPACE, 0);
		send_char(8'hFF, 0);
		send_char(8'h7F, 0);
		send_char(wft_pkg::CH_NEWLINE, 0);
		send_char(wft_pkg::CH_COMMA, 0);
		send_char(wft_pkg::CH_PERIOD, 0);
		send_char(wft_pkg::CH_SPACE, 1);
		send_char(8'h00, 1);
		send_char(8'hFF, 0);
		send_char(8'h7F, 1);
		send_char(8'h01, 0);
		send_char(8'hFE, 0);
		send_char(wft_pkg::CH_PERIOD, 1);
		send_char(8'h01, 0);
		send_char(wft_pkg::CH_COMMA, 0);

		// Repeat the first entry back to back with no idling
		calm = 1;
		repeat (40) begin
			send_char(8'h00, 0);
			send_char(wft_pkg::CH_SPACE, 0);
		end

		// Build a vocabulary larger than the table so it fills up
		for (int v = 0; v < VOCAB_SIZE; v++) begin
			len = $urandom_range(1, 6);
			vocab[v] = {};
			repeat (len) vocab[v].push_back(word_byte());
		end

		// Random text; hold off the receiver early on so the input backs up
		total = 0;
		hold_request = 1;
		while (total < 700) begin
			if (total > 200)
				calm = 0;
			case ($urandom_range(99)) inside
				[0:69]: send_word(vocab[$urandom_range(VOCAB_SIZE - 1)], sent);
				[70:79]: begin
					w = {};
					repeat ($urandom_range(1, 8)) w.push_back(word_byte());
					send_word(w, sent);
				end
				[80:85]: begin
					w = {};
					repeat ($urandom_range(WORD_MAX - 2, WORD_MAX + 6))
						w.push_back(word_byte());
					send_word(w, sent);
				end
				default: begin
					sent = 0;
					repeat ($urandom_range(1, 4)) begin
						send_char(8'($urandom), $urandom_range(3) == 0);
						sent++;
					end
				end
			endcase
			total += sent;
		end
		send_char(wft_pkg::CH_SPACE, 1);

		// Drain: wait for every expected beat, then a latency margin
		char_valid <= 1'b0;
		while (tally.awaited.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (tally.errors == 0 && tally.awaited.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
